/* rtl/core/tfol_pkg.sv */
// ----------------------------------------------------------------------------
// tfol_pkg
// Shared types and constants of the timed first-order low-pass filter.
// ----------------------------------------------------------------------------
package tfol_pkg;

    // field widths
    localparam int SAMPLE_W = 32;
    localparam int TIME_W   = 32;
    localparam int CFG_W    = 24;

    // multiplier operands and product
    localparam int MUL_A_W  = CFG_W + 1;
    localparam int PROD_W   = MUL_A_W + SAMPLE_W;

    // divider: numerator magnitude and divisor
    localparam int NUM_MAG_W = PROD_W - 1;
    localparam int DEN_W     = CFG_W + 1;

    // register reset values
    localparam logic [CFG_W-1:0] TIMEOUT_RESET = 24'd300000;

    // register indexes
    localparam logic [0:0] REG_TIME_CONSTANT = 1'b0;
    localparam logic [0:0] REG_TIMEOUT       = 1'b1;

    // request kinds carried on tuser
    localparam logic OP_FILTER = 1'b0;
    localparam logic OP_RESET  = 1'b1;

    // divider response
    typedef struct packed {
        logic                       done;
        logic signed [SAMPLE_W-1:0] quot;
    } div_rsp_t;

endpackage

/* rtl/core/tfol_mul.sv */
// ----------------------------------------------------------------------------
// tfol_mul
// Shared signed multiplier with a registered product, one product per cycle.
// ----------------------------------------------------------------------------
module tfol_mul (
    input  logic                                    aclk,
    input  logic signed [tfol_pkg::MUL_A_W-1:0]     a,
    input  logic signed [tfol_pkg::SAMPLE_W-1:0]    b,
    output logic signed [tfol_pkg::PROD_W-1:0]      p
);

    logic signed [tfol_pkg::PROD_W-1:0] p_reg;
    logic signed [tfol_pkg::PROD_W-1:0] p_next;

    // full-width signed product
    always_comb begin
        p_next = tfol_pkg::PROD_W'(a) * tfol_pkg::PROD_W'(b);
    end

    always_ff @(posedge aclk) begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule

/* rtl/core/tfol_div.sv */
// ----------------------------------------------------------------------------
// tfol_div
// Radix-2 restoring divider, one quotient bit per cycle, truncating toward
// zero via sign and magnitude.
// ----------------------------------------------------------------------------
module tfol_div (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    start,
    input  logic signed [tfol_pkg::PROD_W-1:0]      num,
    input  logic        [tfol_pkg::DEN_W-1:0]       den,
    output tfol_pkg::div_rsp_t                      rsp
);

    localparam int STEPS = tfol_pkg::NUM_MAG_W;
    localparam int CNT_W = $clog2(STEPS);

    logic [tfol_pkg::NUM_MAG_W-1:0] mag_reg;
    logic [tfol_pkg::DEN_W-1:0]     rem_reg;
    logic [tfol_pkg::DEN_W-1:0]     den_reg;
    logic                           neg_reg;
    logic                           busy_reg;
    logic                           done_reg;
    logic [CNT_W-1:0]               cnt_reg;

    logic [tfol_pkg::PROD_W-1:0]    num_abs;
    logic [tfol_pkg::DEN_W:0]       trial;
    logic [tfol_pkg::DEN_W:0]       diff;
    logic                           fits;
    logic                           last_step;

    // magnitude of the numerator and one trial subtraction
    always_comb begin
        num_abs   = num[tfol_pkg::PROD_W-1] ? tfol_pkg::PROD_W'(-num)
                                            : tfol_pkg::PROD_W'(num);
        trial     = {rem_reg, mag_reg[tfol_pkg::NUM_MAG_W-1]};
        diff      = trial - {1'b0, den_reg};
        fits      = trial >= {1'b0, den_reg};
        last_step = cnt_reg == CNT_W'(STEPS - 1);
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && last_step;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (last_step) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // datapath: quotient bits shift in as numerator bits shift out
    always_ff @(posedge aclk) begin
        if (start) begin
            mag_reg <= num_abs[tfol_pkg::NUM_MAG_W-1:0];
            rem_reg <= '0;
            den_reg <= den;
            neg_reg <= num[tfol_pkg::PROD_W-1];
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[tfol_pkg::DEN_W-1:0] : trial[tfol_pkg::DEN_W-1:0];
            mag_reg <= {mag_reg[tfol_pkg::NUM_MAG_W-2:0], fits};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = neg_reg ? -$signed(mag_reg[tfol_pkg::SAMPLE_W-1:0])
                              : $signed(mag_reg[tfol_pkg::SAMPLE_W-1:0]);

endmodule

/* rtl/core/timed_first_order_lowpass.sv */
// ----------------------------------------------------------------------------
// timed_first_order_lowpass
// First-order low-pass filter with a variable time step from timestamps.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  s_       in   s_tvalid/s_tready    tdata: sample, time_us; tuser: op
//  m_       out  m_tvalid/m_tready    tdata: filtered
//  cfg_     in   cfg_we (no wait)     cfg_addr, cfg_wdata
//
//  A filtered request puts its result on m_ after the 56 one-bit steps of
//  the shared divider plus two passes through the shared multiplier.
//  Reset, timeout and zero time-constant requests skip both. One request
//  is in flight at a time; s_tready is high only when idle, from the cycle
//  after the result is loaded. A finished result waits in the output
//  register while the next request is taken. aresetn is synchronous,
//  active low.
// ----------------------------------------------------------------------------
module timed_first_order_lowpass (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // input requests
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [63:0]                             s_tdata,   // sample, time_us
    input  logic                                    s_tuser,   // op
    // results
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [31:0]                             m_tdata,   // filtered
    // configuration writes
    input  logic                                    cfg_we,
    input  logic [0:0]                              cfg_addr,
    input  logic [tfol_pkg::CFG_W-1:0]              cfg_wdata
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL_A,
        ST_MUL_B,
        ST_SUM,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;

    logic [tfol_pkg::CFG_W-1:0]           tf_reg;
    logic [tfol_pkg::CFG_W-1:0]           timeout_reg;
    logic signed [tfol_pkg::SAMPLE_W-1:0] last_out_reg, last_out_next;
    logic [tfol_pkg::TIME_W-1:0]          last_time_reg, last_time_next;

    logic                                 op_reg;
    logic signed [tfol_pkg::SAMPLE_W-1:0] x_reg;
    logic [tfol_pkg::TIME_W-1:0]          now_reg;
    logic signed [tfol_pkg::SAMPLE_W-1:0] result_reg, result_next;
    logic                                 upd_reg, upd_next;
    logic signed [tfol_pkg::PROD_W-1:0]   acc_reg, acc_next;
    logic [31:0]                          m_tdata_reg, m_tdata_next;

    logic                                 s_accept;
    logic                                 out_free;
    logic [tfol_pkg::TIME_W-1:0]          dt;
    logic signed [tfol_pkg::MUL_A_W-1:0]  mul_a;
    logic signed [tfol_pkg::SAMPLE_W-1:0] mul_b;
    logic signed [tfol_pkg::PROD_W-1:0]   prod;
    logic                                 div_start;
    logic signed [tfol_pkg::PROD_W-1:0]   div_num;
    logic [tfol_pkg::DEN_W-1:0]           div_den;
    tfol_pkg::div_rsp_t                   div_rsp;

    assign s_tready = state_reg == ST_IDLE;
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // elapsed time, wrapping
    assign dt = now_reg - last_time_reg;

    // shared multiplier: first Tf * y_prev, then dt * x
    always_comb begin
        if (state_reg == ST_MUL_B) begin
            mul_a = $signed({1'b0, dt[tfol_pkg::CFG_W-1:0]});
            mul_b = x_reg;
        end else begin
            mul_a = $signed({1'b0, tf_reg});
            mul_b = last_out_reg;
        end
    end

    tfol_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (prod)
    );

    // divider operands
    assign div_start = state_reg == ST_SUM;
    assign div_num   = acc_reg + prod;
    assign div_den   = {1'b0, tf_reg} + {1'b0, dt[tfol_pkg::CFG_W-1:0]};

    tfol_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .rsp     (div_rsp)
    );

    // sequencer
    always_comb begin
        state_next     = state_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        result_next    = result_reg;
        upd_next       = upd_reg;
        acc_next       = acc_reg;
        last_out_next  = last_out_reg;
        last_time_next = last_time_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (op_reg == tfol_pkg::OP_RESET) begin
                    result_next = '0;
                    upd_next    = 1'b1;
                    state_next  = ST_OUT;
                end else if (dt > {8'b0, timeout_reg}) begin
                    result_next = x_reg;
                    upd_next    = 1'b1;
                    state_next  = ST_OUT;
                end else if (tf_reg == '0) begin
                    result_next = x_reg;
                    upd_next    = 1'b0;
                    state_next  = ST_OUT;
                end else begin
                    state_next  = ST_MUL_A;
                end
            end
            ST_MUL_A: begin
                state_next = ST_MUL_B;
            end
            ST_MUL_B: begin
                acc_next   = prod;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    result_next = div_rsp.quot;
                    upd_next    = 1'b1;
                    state_next  = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = result_reg;
                    if (upd_reg) begin
                        last_out_next  = result_reg;
                        last_time_next = now_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state, registered outputs and filter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_tvalid_reg  <= 1'b0;
            m_tdata_reg   <= '0;
            last_out_reg  <= '0;
            last_time_reg <= '0;
        end else begin
            state_reg     <= state_next;
            m_tvalid_reg  <= m_tvalid_next;
            m_tdata_reg   <= m_tdata_next;
            last_out_reg  <= last_out_next;
            last_time_reg <= last_time_next;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tf_reg      <= '0;
            timeout_reg <= tfol_pkg::TIMEOUT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                tfol_pkg::REG_TIME_CONSTANT: tf_reg      <= cfg_wdata;
                tfol_pkg::REG_TIMEOUT:       timeout_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg  <= s_tuser;
            x_reg   <= $signed(s_tdata[31:0]);
            now_reg <= s_tdata[63:32];
        end
        result_reg  <= result_next;
        upd_reg     <= upd_next;
        acc_reg     <= acc_next;
    end

    // one request in flight at a time
    a_single_request: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while another is in flight");

    // divider completes only while the sequencer waits on it
    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> state_reg == ST_DIV)
        else $error("divider finished outside the divide phase");

    // a result appears only out of the delivery state
    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside the delivery state");

endmodule

/* tb/timed_first_order_lowpass_tb.sv */
// ----------------------------------------------------------------------------
// timed_first_order_lowpass_tb
// Self-checking bench for the timed first-order low-pass filter. A short
// directed table covers reset requests, the field extremes, the timeout edge,
// time running backwards, zero dt and a zero time constant. Random phases
// follow, each with fresh register settings. Results are checked against the
// row's value if given, else an in-bench model; stream sides idle at random.
// ----------------------------------------------------------------------------
module timed_first_order_lowpass_tb;

    localparam int ITEM_TARGET  = 1850;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int TAIL_CYCLES  = 80;
    localparam logic [tfol_pkg::CFG_W-1:0] CFG_MAX = {tfol_pkg::CFG_W{1'b1}};

    // one row of the directed table: a register write or a request
    typedef struct {
        logic                          is_cfg;
        logic [0:0]                    reg_idx;
        logic [tfol_pkg::CFG_W-1:0]    wdata;
        logic                          op;
        logic [tfol_pkg::SAMPLE_W-1:0] sample;
        logic [tfol_pkg::TIME_W-1:0]   stamp;
        logic                          typed;
        logic [tfol_pkg::SAMPLE_W-1:0] want;
    } stim_row_t;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [63:0]                   s_tdata;
    logic                          s_tuser;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [31:0]                   m_tdata;
    logic                          cfg_we;
    logic [0:0]                    cfg_addr;
    logic [tfol_pkg::CFG_W-1:0]    cfg_wdata;

    // filter model state and registers
    logic [tfol_pkg::CFG_W-1:0]           flt_tc;
    logic [tfol_pkg::CFG_W-1:0]           flt_timeout;
    logic signed [tfol_pkg::SAMPLE_W-1:0] flt_last_out;
    logic [tfol_pkg::TIME_W-1:0]          flt_last_time;

    logic [tfol_pkg::SAMPLE_W-1:0] filtered_q[$];
    stim_row_t                     plan_q[$];
    int                            errors = 0;
    int                            cycles = 0;
    int                            burst_left;
    logic                          steady;

    timed_first_order_lowpass uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // filter model: one request in, expected filtered value out
    function automatic logic [tfol_pkg::SAMPLE_W-1:0] lowpass_predict(
        input logic op, input logic signed [tfol_pkg::SAMPLE_W-1:0] x,
        input logic [tfol_pkg::TIME_W-1:0] now);
        logic [tfol_pkg::TIME_W-1:0] dt;
        longint                      num;
        longint                      den;
        longint                      y;
        if (op == tfol_pkg::OP_RESET) begin
            flt_last_out  = '0;
            flt_last_time = now;
            return '0;
        end
        dt = now - flt_last_time;
        // long gap or time running backwards: snap to the sample
        if (dt > {8'd0, flt_timeout}) begin
            flt_last_out  = x;
            flt_last_time = now;
            return x;
        end
        // filtering disabled, state untouched
        if (flt_tc == '0)
            return x;
        num = longint'(flt_tc) * longint'(flt_last_out) + longint'(dt) * longint'(x);
        den = longint'(flt_tc) + longint'(dt);
        y   = num / den;
        flt_last_out  = y[tfol_pkg::SAMPLE_W-1:0];
        flt_last_time = now;
        return y[tfol_pkg::SAMPLE_W-1:0];
    endfunction

    function automatic stim_row_t directed_item(
        input logic op, input logic [31:0] sample, input logic [31:0] stamp,
        input logic typed, input logic [31:0] want);
        stim_row_t r;
        r.is_cfg  = 1'b0;
        r.reg_idx = tfol_pkg::REG_TIME_CONSTANT;
        r.wdata   = '0;
        r.op      = op;
        r.sample  = sample;
        r.stamp   = stamp;
        r.typed   = typed;
        r.want    = want;
        return r;
    endfunction

    function automatic stim_row_t directed_cfg(input logic [0:0] idx,
                                               input logic [tfol_pkg::CFG_W-1:0] v);
        stim_row_t r;
        r = directed_item(tfol_pkg::OP_FILTER, '0, '0, 1'b0, '0);
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.wdata   = v;
        return r;
    endfunction

    // register write once nothing is in flight
    task automatic write_reg(input logic [0:0] idx, input logic [tfol_pkg::CFG_W-1:0] v);
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (filtered_q.size() != 0)
            @(negedge aclk);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == tfol_pkg::REG_TIME_CONSTANT)
            flt_tc = v;
        else
            flt_timeout = v;
    endtask

    // one request on the input stream, bursts with random gaps unless steady
    task automatic send_request(
        input logic op, input logic [31:0] sample, input logic [31:0] stamp,
        input logic typed, input logic [31:0] want);
        logic [tfol_pkg::SAMPLE_W-1:0] exp_val;
        if (burst_left == 0) begin
            if (!steady) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 20);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {stamp, sample};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        burst_left = burst_left - 1;
        exp_val = lowpass_predict(op, sample, stamp);
        filtered_q.push_back(typed ? want : exp_val);
        @(negedge aclk);
    endtask

    // result checker
    always @(posedge aclk) begin
        logic [tfol_pkg::SAMPLE_W-1:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (filtered_q.size() == 0) begin
                $error("filtered: expected none, actual %0d", $signed(m_tdata));
                errors++;
            end else begin
                want = filtered_q.pop_front();
                if (m_tdata !== want) begin
                    $error("filtered: expected %0d, actual %0d", $signed(want),
                           $signed(m_tdata));
                    errors++;
                end
            end
        end
    end

    // receiver stall patterns
    initial begin
        int mode;
        int span;
        int tick;
        m_tready = 1'b0;
        tick = 0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(50, 300);
            repeat (span) begin
                @(negedge aclk);
                tick++;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= (tick % 4 == 0);
                    default: m_tready <= (tick % 24 >= 20);
                endcase
            end
        end
    end

    // stimulus
    initial begin
        stim_row_t                   row;
        int                          sent;
        int                          phase_len;
        int                          r;
        logic                        op;
        logic [31:0]                 sample;
        logic [31:0]                 dt;
        logic [tfol_pkg::CFG_W-1:0]  tc_v;
        logic [tfol_pkg::CFG_W-1:0]  to_v;

        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = tfol_pkg::OP_FILTER;
        cfg_we     = 1'b0;
        cfg_addr   = tfol_pkg::REG_TIME_CONSTANT;
        cfg_wdata  = '0;
        burst_left = 0;
        steady     = 1'b0;
        flt_tc        = '0;
        flt_timeout   = tfol_pkg::TIMEOUT_RESET;
        flt_last_out  = '0;
        flt_last_time = '0;

        // directed table, reset register values first
        plan_q.push_back(directed_item(tfol_pkg::OP_RESET,  32'h12345678, 32'd0,
                                       1'b1, 32'd0));
        plan_q.push_back(directed_item(tfol_pkg::OP_FILTER, 32'h7FFFFFFF, 32'd100,
                                       1'b1, 32'h7FFFFFFF));
        plan_q.push_back(directed_item(tfol_pkg::OP_FILTER, 32'h80000000, 32'd200,
                                       1'b1, 32'h80000000));
        plan_q.push_back(directed_item(tfol_pkg::OP_FILTER, 32'h00010000, 32'd400000,
                                       1'b1, 32'h00010000));
        plan_q.push_back(directed_cfg(tfol_pkg::REG_TIME_CONSTANT, 24'd1000));
        // zero dt keeps the stored value
        plan_q.push_back(directed_item(tfol_pkg::OP_FILTER, 32'h00020000, 32'd400000,
                                       1'b1, 32'h00010000));
        plan_q.push_back(directed_item(tfol_pkg::OP_FILTER, 32'h7FFFFFFF, 32'd401000,
                                       1'b0, '0));
        plan_q.push_back(directed_item(tfol_pkg::OP_FILTER, 32'h80000000, 32'd402000,
                                       1'b0, '0));
        // time running backwards wraps into a timeout
        plan_q.push_back(directed_item(tfol_pkg::OP_FILTER, 32'hFFFF0000, 32'd300000,
                                       1'b1, 32'hFFFF0000));
        // dt equal to the timeout still filters, one more snaps
        plan_q.push_back(directed_item(tfol_pkg::OP_FILTER, 32'h00030000, 32'd600000,
                                       1'b0, '0));
        plan_q.push_back(directed_item(tfol_pkg::OP_FILTER, 32'h00050000, 32'd900001,
                                       1'b1, 32'h00050000));
        plan_q.push_back(directed_cfg(tfol_pkg::REG_TIME_CONSTANT, CFG_MAX));
        plan_q.push_back(directed_cfg(tfol_pkg::REG_TIMEOUT, CFG_MAX));
        plan_q.push_back(directed_item(tfol_pkg::OP_RESET,  32'h00000000, 32'hFFFFFFFF,
                                       1'b1, 32'd0));
        plan_q.push_back(directed_item(tfol_pkg::OP_FILTER, 32'h7FFFFFFF, 32'h00FFFFFE,
                                       1'b0, '0));
        plan_q.push_back(directed_item(tfol_pkg::OP_FILTER, 32'h80000000, 32'h01FFFFFD,
                                       1'b0, '0));
        plan_q.push_back(directed_cfg(tfol_pkg::REG_TIMEOUT, '0));
        plan_q.push_back(directed_item(tfol_pkg::OP_FILTER, 32'h00001234, 32'h01FFFFFD,
                                       1'b0, '0));
        plan_q.push_back(directed_item(tfol_pkg::OP_FILTER, 32'h00005678, 32'h01FFFFFE,
                                       1'b1, 32'h00005678));
        plan_q.push_back(directed_cfg(tfol_pkg::REG_TIME_CONSTANT, 24'd1));
        plan_q.push_back(directed_cfg(tfol_pkg::REG_TIMEOUT, CFG_MAX));
        plan_q.push_back(directed_item(tfol_pkg::OP_FILTER, 32'hFFFFFFFF, 32'h02000003,
                                       1'b0, '0));
        plan_q.push_back(directed_item(tfol_pkg::OP_RESET,  32'hFFFFFFFF, 32'hAAAAAAAA,
                                       1'b1, 32'd0));
        plan_q.push_back(directed_item(tfol_pkg::OP_FILTER, 32'h55555555, 32'hAAAAAAAB,
                                       1'b0, '0));

        // reset
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (plan_q[i]) begin
            row = plan_q[i];
            if (row.is_cfg)
                write_reg(row.reg_idx, row.wdata);
            else
                send_request(row.op, row.sample, row.stamp, row.typed, row.want);
        end

        // random phases, each with its own settings
        sent = 0;
        while (sent < ITEM_TARGET) begin
            r = $urandom_range(0, 9);
            case (r)
                0:       tc_v = '0;
                1:       tc_v = 24'd1;
                2:       tc_v = CFG_MAX;
                3, 4:    tc_v = tfol_pkg::CFG_W'($urandom_range(1, 100));
                5, 6, 7: tc_v = tfol_pkg::CFG_W'($urandom_range(1000, 100000));
                default: tc_v = tfol_pkg::CFG_W'($urandom_range(0, CFG_MAX));
            endcase
            r = $urandom_range(0, 9);
            case (r)
                0:       to_v = '0;
                1:       to_v = CFG_MAX;
                2, 3:    to_v = tfol_pkg::TIMEOUT_RESET;
                4, 5:    to_v = tfol_pkg::CFG_W'($urandom_range(1, 1000));
                default: to_v = tfol_pkg::CFG_W'($urandom_range(0, CFG_MAX));
            endcase
            write_reg(tfol_pkg::REG_TIME_CONSTANT, tc_v);
            write_reg(tfol_pkg::REG_TIMEOUT, to_v);
            steady    = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(40, 120);

            repeat (phase_len) begin
                op = ($urandom_range(0, 99) < 3) ? tfol_pkg::OP_RESET : tfol_pkg::OP_FILTER;
                r  = $urandom_range(0, 9);
                case (r)
                    0:       sample = 32'h7FFFFFFF;
                    1:       sample = 32'h80000000;
                    2:       sample = $urandom_range(0, 255) - 128;
                    3:       sample = flt_last_out + ($urandom_range(0, 2047) - 1024);
                    default: sample = $urandom;
                endcase
                r = $urandom_range(0, 99);
                if (r < 70)
                    dt = $urandom_range(0, flt_timeout);
                else if (r < 78)
                    dt = flt_timeout;
                else if (r < 84)
                    dt = flt_timeout + 1;
                else if (r < 88)
                    dt = '0;
                else if (r < 94)
                    dt = -$urandom_range(1, 1000);
                else
                    dt = $urandom;
                send_request(op, sample, flt_last_time + dt, 1'b0, '0);
                sent++;
            end
        end

        // drain
        s_tvalid <= 1'b0;
        while (filtered_q.size() != 0)
            @(negedge aclk);
        repeat (TAIL_CYCLES) @(negedge aclk);

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
